// ===== src/mrs_pkg.sv =====
package mrs_pkg;

	localparam int REG_COUNT   = 128;
	localparam int FRAME_BYTES = 256;
	localparam int MAX_READ    = 29;

	localparam int REG_AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam int FB_AW  = $clog2(FRAME_BYTES);
	localparam int LEN_W  = FB_AW + 1;
	localparam int CNT_W  = $clog2(REG_COUNT + 1);

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0] FC_READ   = 8'h03;
	localparam logic [7:0] FC_WRITE  = 8'h10;
	localparam logic [7:0] FC_EXC    = 8'h80;
	localparam logic [7:0] FC_RD_EXC = 8'h83;
	localparam logic [7:0] FC_WR_EXC = 8'h90;
	localparam logic [7:0] EX_FUNC   = 8'h01;
	localparam logic [7:0] EX_RANGE  = 8'h02;
	localparam logic [7:0] EX_COUNT  = 8'h03;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_end;
	} rx_item_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       tx_last;
	} tx_item_t;

	typedef enum logic [1:0] {
		K_EXC,
		K_READ,
		K_WRITE
	} cmd_kind_t;

	// one classified request handed from front to back
	typedef struct packed {
		cmd_kind_t        kind;
		logic [5:0][7:0]  hdr;
		logic [2:0]       hlast;
		logic [REG_AW-1:0] start;
		logic [CNT_W-1:0] count;
	} cmd_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_HDR,
		B_RFETCH,
		B_RHI,
		B_RLO,
		B_WA,
		B_WB,
		B_WC,
		B_CRCL,
		B_CRCH
	} back_state_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (r[0]) begin
				r = (r >> 1) ^ CRC_POLY;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

endpackage

// ===== src/mrs_front.sv =====
module mrs_front
	import mrs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  rx_item_t         rx,
	input  logic [7:0]       slave_address,
	input  logic [FB_AW-1:0] rd_addr,
	output logic [7:0]       rd_data,
	output logic             push,
	output cmd_t             cmd
);

	logic [7:0]       store [FRAME_BYTES];
	logic [LEN_W-1:0] len_q;
	logic             ovf_q;
	logic [15:0]      crc_q, crc_d1_q;
	logic [7:0]       prev_q;
	logic [5:0][7:0]  hdr_q;

	logic             full;
	logic [LEN_W-1:0] n;
	logic [15:0]      start16, cnt16;
	logic             range_bad, drop;
	logic [16:0]      range_end;
	logic [17:0]      wr_need;

	assign full = (len_q == LEN_W'(FRAME_BYTES));

	always_ff @(posedge clk) begin
		if (accept && !full) begin
			store[len_q[FB_AW-1:0]] <= rx.rx_byte;
		end
		rd_data <= store[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			ovf_q    <= 1'b0;
			crc_q    <= CRC_INIT;
			crc_d1_q <= CRC_INIT;
			prev_q   <= '0;
			hdr_q    <= '0;
		end else if (accept) begin
			if (!full) begin
				len_q    <= len_q + 1'b1;
				crc_d1_q <= crc_q;
				crc_q    <= crc_byte(crc_q, rx.rx_byte);
				prev_q   <= rx.rx_byte;
				if (len_q < LEN_W'(6)) begin
					hdr_q[len_q[2:0]] <= rx.rx_byte;
				end
			end else begin
				ovf_q <= 1'b1;
			end
			if (rx.frame_end) begin
				len_q <= '0;
				ovf_q <= 1'b0;
				crc_q <= CRC_INIT;
			end
		end
	end

	// classification at frame end; header bytes were all taken earlier when needed
	always_comb begin
		n         = full ? len_q : len_q + 1'b1;
		start16   = {hdr_q[2], hdr_q[3]};
		cnt16     = {hdr_q[4], hdr_q[5]};
		range_end = {9'd0, hdr_q[3]} + {1'b0, cnt16};
		range_bad = (hdr_q[2] != 8'h00) || (range_end > 17'(REG_COUNT));
		wr_need   = {1'b0, cnt16, 1'b0} + 18'd9;
		drop      = full || ovf_q || (n < LEN_W'(4)) || (hdr_q[0] != slave_address)
			|| (crc_d1_q != {rx.rx_byte, prev_q});
		cmd       = '0;
		cmd.hdr   = hdr_q;
		cmd.hlast = 3'd2;
		cmd.start = REG_AW'(start16);
		cmd.count = CNT_W'(cnt16);
		cmd.kind  = K_EXC;
		case (hdr_q[1])
			FC_READ: begin
				if (n < LEN_W'(8)) begin
					drop = 1'b1;
				end else if (cnt16 > 16'(MAX_READ)) begin
					cmd.hdr[1] = FC_RD_EXC;
					cmd.hdr[2] = EX_COUNT;
				end else if (range_bad) begin
					cmd.hdr[1] = FC_RD_EXC;
					cmd.hdr[2] = EX_RANGE;
				end else begin
					cmd.kind   = K_READ;
					cmd.hdr[2] = {cnt16[6:0], 1'b0};
				end
			end
			FC_WRITE: begin
				if (n < LEN_W'(9) || {9'd0, n} < wr_need) begin
					drop = 1'b1;
				end else if (range_bad) begin
					cmd.hdr[1] = FC_WR_EXC;
					cmd.hdr[2] = EX_RANGE;
				end else begin
					cmd.kind  = K_WRITE;
					cmd.hlast = 3'd5;
				end
			end
			default: begin
				cmd.hdr[1] = hdr_q[1] | FC_EXC;
				cmd.hdr[2] = EX_FUNC;
			end
		endcase
		push = accept && rx.frame_end && !drop;
	end

endmodule

// ===== src/mrs_cmd_fifo.sv =====
module mrs_cmd_fifo
	import mrs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t din,
	input  logic pop,
	output cmd_t dout,
	output logic empty
);

	cmd_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && cnt_q != 2'd2) begin
			mem_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push && cnt_q != 2'd2) begin
				wp_q <= ~wp_q;
			end
			if (pop && !empty) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'((push && cnt_q != 2'd2) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
		end
	end

endmodule

// ===== src/mrs_back.sv =====
module mrs_back
	import mrs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  cmd_t             q_cmd,
	output logic             q_pop,
	output logic [FB_AW-1:0] rd_addr,
	input  logic [7:0]       rd_data,
	output logic             active,
	output logic             strobe,
	output tx_item_t         tx
);

	back_state_t       st_q, st_d;
	cmd_t              cmd_q;
	logic [CNT_W-1:0]  k_q;
	logic [2:0]        idx_q;
	logic [15:0]       crc_q;
	logic [7:0]        hi_q;
	logic [15:0]       regs [REG_COUNT];
	logic [REG_COUNT-1:0] vld_q;
	logic [15:0]       rd_q;
	logic              rdv_q;
	logic [15:0]       rval;

	logic              emit, elast, ecrc, do_wr;
	logic [7:0]        eb;
	logic [REG_AW-1:0] raddr;
	logic              k_done;

	assign active = (st_q != B_IDLE);
	assign rval   = rdv_q ? rd_q : 16'h0000;
	assign raddr  = REG_AW'({1'b0, cmd_q.start} + (REG_AW + 1)'(k_q));
	assign k_done = (k_q + 1'b1 == cmd_q.count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d    = st_q;
		q_pop   = 1'b0;
		emit    = 1'b0;
		elast   = 1'b0;
		ecrc    = 1'b1;
		eb      = '0;
		do_wr   = 1'b0;
		rd_addr = FB_AW'((FB_AW + 2)'(7) + (FB_AW + 2)'({k_q, 1'b0}));
		case (st_q)
			B_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					st_d  = (q_cmd.kind == K_WRITE && q_cmd.count != '0) ? B_WA : B_HDR;
				end
			end
			B_HDR: begin
				emit = 1'b1;
				eb   = cmd_q.hdr[idx_q];
				if (idx_q == cmd_q.hlast) begin
					st_d = (cmd_q.kind == K_READ && cmd_q.count != '0) ? B_RFETCH : B_CRCL;
				end
			end
			B_RFETCH: st_d = B_RHI;
			B_RHI: begin
				emit = 1'b1;
				eb   = rval[15:8];
				st_d = B_RLO;
			end
			B_RLO: begin
				emit = 1'b1;
				eb   = rval[7:0];
				st_d = k_done ? B_CRCL : B_RFETCH;
			end
			B_WA: st_d = B_WB;
			B_WB: begin
				rd_addr = FB_AW'((FB_AW + 2)'(8) + (FB_AW + 2)'({k_q, 1'b0}));
				st_d    = B_WC;
			end
			B_WC: begin
				do_wr = 1'b1;
				st_d  = k_done ? B_HDR : B_WA;
			end
			B_CRCL: begin
				emit = 1'b1;
				ecrc = 1'b0;
				eb   = crc_q[7:0];
				st_d = B_CRCH;
			end
			B_CRCH: begin
				emit  = 1'b1;
				ecrc  = 1'b0;
				elast = 1'b1;
				eb    = crc_q[15:8];
				st_d  = B_IDLE;
			end
			default: st_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
			k_q   <= '0;
			idx_q <= '0;
			crc_q <= CRC_INIT;
		end else begin
			if (st_q == B_HDR) begin
				idx_q <= idx_q + 1'b1;
			end
			if (st_q == B_RLO || st_q == B_WC) begin
				k_q <= k_q + 1'b1;
			end
			if (emit && ecrc) begin
				crc_q <= crc_byte(crc_q, eb);
			end
		end
		if (st_q == B_WB) begin
			hi_q <= rd_data;
		end
		if (emit) begin
			tx <= '{tx_byte: eb, tx_last: elast};
		end
		if (do_wr) begin
			regs[raddr] <= {hi_q, rd_data};
		end
		rd_q <= regs[raddr];
	end

	// valid bits stand in for the all-zero reset of the register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rdv_q  <= 1'b0;
			strobe <= 1'b0;
		end else begin
			if (do_wr) begin
				vld_q[raddr] <= 1'b1;
			end
			rdv_q  <= vld_q[raddr];
			strobe <= emit;
		end
	end

endmodule

// ===== src/modbus_rtu_register_slave_unit.sv =====
// channel   direction  handshake           payload
// rx        in         start / busy        rx_item_t  (rx_byte, frame_end)
// tx        out        strobe, no stall    tx_item_t  (tx_byte, tx_last)
// cfg       in         cfg_we              cfg_data = slave address
//
// One request byte is taken per cycle while busy is low; a byte that closes a
// frame is classified at once. If the frame is kept, busy then stays high while
// the back end runs it: header and CRC bytes go out one by one, each register
// read is a fetch and then two bytes out, and each register written takes two store reads.
// Reset clears the register file through per-entry valid bits; no sweep.
module modbus_rtu_register_slave_unit
	import mrs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  rx_item_t rx,
	input  logic     cfg_we,
	input  logic [7:0] cfg_data,
	output logic     strobe,
	output tx_item_t tx
);

	logic [7:0]       addr_q;
	logic             accept, push, pop, empty, active;
	cmd_t             f_cmd, q_cmd;
	logic [FB_AW-1:0] rd_addr;
	logic [7:0]       rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= 8'd1;
		end else if (cfg_we) begin
			addr_q <= cfg_data;
		end
	end

	assign busy   = !empty || active;
	assign accept = start && !busy;

	mrs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.rx            (rx),
		.slave_address (addr_q),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data),
		.push          (push),
		.cmd           (f_cmd)
	);

	mrs_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (f_cmd),
		.pop    (pop),
		.dout   (q_cmd),
		.empty  (empty)
	);

	mrs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (empty),
		.q_cmd   (q_cmd),
		.q_pop   (pop),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.active  (active),
		.strobe  (strobe),
		.tx      (tx)
	);

endmodule

// ===== src/mrs_checker.sv =====
module mrs_checker
	import mrs_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input logic     strobe,
	input tx_item_t tx
);

	// no answer can start in the cycle right after an item is taken
	a_no_tx_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !strobe)
		else $error("response byte right after an accepted item");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && tx.tx_last |=> !strobe)
		else $error("byte follows the last byte of a response");

	a_idle_at_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && tx.tx_last |-> !busy)
		else $error("still busy on the last response byte");

endmodule

bind modbus_rtu_register_slave_unit mrs_checker u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.strobe (strobe),
	.tx     (tx)
);
